### sv/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search block.
`timescale 1ns / 1ps
package wbps_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned PatternRegBytes = 16;
  localparam int unsigned LenW = 5;
  localparam int unsigned CntW = 23;
  localparam int unsigned OffW = 22;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  localparam logic [CntW-1:0] RegionBytes = 23'd4194304;

  localparam logic [CfgIdxW-1:0] CfgPatternLow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCareMask = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPatternLength = 2'd3;

  typedef logic [PatternRegBytes-1:0][7:0] pat_t;

  typedef struct packed {
    pat_t                       pattern;
    logic [PatternRegBytes-1:0] care;
    logic [LenW-1:0]            len;
  } cfg_t;

endpackage

### sv/wildcard_byte_pattern_search_top.sv
// Top level of the wildcard byte pattern search block.
// Takes one byte beat per cycle with no gaps needed; a beat passes through one
// input register, then the window compare into the result register, which
// presents its result. The rate is set by the combinational masked compare of
// all 16 window slots. While a finished result waits on out_stall_i, in_stall_o
// is high and both registers hold, so input beats are held off until the result
// is taken. Matches are reported once per region at the beat that completes
// them; a region without a match reports found 0 on its last beat.
`timescale 1ns / 1ps
module wildcard_byte_pattern_search_top import wbps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                region_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                found_o,
  output logic [OffW-1:0]     match_offset_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t            cfg;
  logic            adv;
  logic            s1_valid_q;
  logic [7:0]      s1_byte_q;
  logic            s1_last_q;
  logic            step, emit, found;
  logic [OffW-1:0] offset;
  logic            out_valid_q;
  logic            found_q;
  logic [OffW-1:0] offset_q;

  wbps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // advance the pipe whenever the result register is free or being taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign step       = s1_valid_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= region_end_i;
    end
  end

  wbps_match u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .cfg_i    (cfg),
    .emit_o   (emit),
    .found_o  (found),
    .offset_o (offset)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= step && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      found_q  <= found;
      offset_q <= offset;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

endmodule

### sv/wbps_cfg.sv
// Configuration register file: pattern bytes, care mask and pattern length.
`timescale 1ns / 1ps
module wbps_cfg import wbps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [63:0]               pat_lo_q, pat_lo_d;
  logic [63:0]               pat_hi_q, pat_hi_d;
  logic [PatternRegBytes-1:0] care_q, care_d;
  logic [LenW-1:0]           len_q, len_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    care_d   = care_q;
    len_d    = len_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPatternLow:    pat_lo_d = cfg_data_i[63:0];
        CfgPatternHigh:   pat_hi_d = cfg_data_i[63:0];
        CfgCareMask:      care_d   = cfg_data_i[PatternRegBytes-1:0];
        CfgPatternLength: len_d    = cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '1;
      len_q    <= LenW'(1);
    end else begin
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
      care_q   <= care_d;
      len_q    <= len_d;
    end
  end

  assign cfg_o.pattern = {pat_hi_q, pat_lo_q};
  assign cfg_o.care    = care_q;
  assign cfg_o.len     = len_q;

endmodule

### sv/wbps_match.sv
// Byte window, region position count and the parallel masked compare.
`timescale 1ns / 1ps
module wbps_match import wbps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  cfg_t            cfg_i,
  output logic            emit_o,
  output logic            found_o,
  output logic [OffW-1:0] offset_o
);

  logic [MaxPattern-1:0][7:0] win_q, win_d, win_new;
  logic [CntW-1:0]            seen_q, seen_d, seen_new, diff;
  logic                       rep_q, rep_d;
  logic [LenW-1:0]            len_eff;
  logic                       active, match, hit;

  // clamp length to the window size
  assign len_eff = (cfg_i.len > LenW'(MaxPattern)) ? LenW'(MaxPattern) : cfg_i.len;

  always_comb begin
    win_new[0] = byte_i;
    for (int k = 1; k < MaxPattern; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  // pattern byte i lines up with window slot len-1-i (slot 0 is newest)
  always_comb begin
    logic [LenW-1:0] idx;
    match = 1'b1;
    idx   = '0;
    for (int i = 0; i < MaxPattern; i++) begin
      idx = len_eff - LenW'(1) - LenW'(i);
      if ((LenW'(i) < len_eff) && cfg_i.care[i] &&
          (win_new[idx[3:0]] != cfg_i.pattern[i])) begin
        match = 1'b0;
      end
    end
  end

  assign active   = !rep_q && (seen_q < RegionBytes);
  assign seen_new = seen_q + CntW'(1);
  assign diff     = seen_new - CntW'(len_eff);
  assign hit      = active && (seen_new >= CntW'(len_eff)) && match;

  assign emit_o   = hit || (last_i && !rep_q);
  assign found_o  = hit;
  assign offset_o = hit ? diff[OffW-1:0] : '0;

  always_comb begin
    win_d  = win_q;
    seen_d = seen_q;
    rep_d  = rep_q;
    if (step_i) begin
      if (last_i) begin
        // drop region state after the last beat
        win_d  = '0;
        seen_d = '0;
        rep_d  = 1'b0;
      end else if (active) begin
        win_d  = win_new;
        seen_d = seen_new;
        rep_d  = hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      seen_q <= '0;
      rep_q  <= 1'b0;
    end else begin
      win_q  <= win_d;
      seen_q <= seen_d;
      rep_q  <= rep_d;
    end
  end

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && found_o) |-> !rep_q)
    else $error("second match reported in one region");

  a_region_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (seen_q == '0) && !rep_q)
    else $error("region state not cleared after last beat");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= RegionBytes)
    else $error("position count ran past region size");

  a_miss_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && emit_o && !found_o) |-> last_i)
    else $error("not-found result off the last beat");

endmodule
